[rtl/mads_pkg.sv]
`default_nettype none

package mads_pkg;

    localparam int MAX_PAIRS_DEF = 8;

    localparam int DATA_W     = 10;  // height and length values
    localparam int COST_W     = 14;  // running and best cost
    localparam int OUT_COST_W = 13;  // total_cost field
    localparam int PIDX_W     = 3;   // person_index field
    localparam int ITEM_W     = 4;   // assigned_item field
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;

    localparam logic [COST_W-1:0] COST_ALL_ONES = '1;

    typedef enum logic [2:0] {
        ST_LOAD   = 3'b001,
        ST_SEARCH = 3'b010,
        ST_EMIT   = 3'b100
    } state_t;

    typedef struct packed {
        logic load;      // input item accepted
        logic start;     // accepted item ends the set
        logic step;      // one search step
        logic emit_adv;  // result item taken
    } cmd_t;

    typedef struct packed {
        logic search_done;
        logic emit_last;
    } status_t;

endpackage

`default_nettype wire

[rtl/mads_ctrl.sv]
`default_nettype none

module mads_ctrl
(
    input  wire                clk,
    input  wire                rst_n,
    input  wire                in_valid,
    input  wire                in_last,
    output logic               in_ready,
    output logic               out_valid,
    input  wire                out_ready,
    input  wire mads_pkg::status_t status,
    output mads_pkg::cmd_t     cmd
);
    import mads_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next   = state_reg;
        in_ready     = 1'b0;
        out_valid    = 1'b0;
        cmd          = '0;
        unique case (state_reg)
            ST_LOAD:
            begin
                in_ready  = 1'b1;
                cmd.load  = in_valid;
                cmd.start = in_valid && in_last;
                if (in_valid && in_last)
                begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                cmd.step = 1'b1;
                if (status.search_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                out_valid    = 1'b1;
                cmd.emit_adv = out_ready;
                if (out_ready && status.emit_last)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

[rtl/mads_datapath.sv]
`default_nettype none

module mads_datapath
#(
    parameter int MAX_PAIRS = mads_pkg::MAX_PAIRS_DEF
)
(
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire  mads_pkg::cmd_t          cmd,
    input  wire  [mads_pkg::DATA_W-1:0]   in_height,
    input  wire  [mads_pkg::DATA_W-1:0]   in_length,
    output mads_pkg::status_t             status,
    output logic [mads_pkg::PIDX_W-1:0]   out_person,
    output logic [mads_pkg::ITEM_W-1:0]   out_item,
    output logic [mads_pkg::OUT_COST_W-1:0] out_cost
);
    import mads_pkg::*;

    localparam int IDX_W = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
    localparam int CNT_W = $clog2(MAX_PAIRS + 1);

    // pair stores and search stacks
    logic [DATA_W-1:0] height_reg [MAX_PAIRS];
    logic [DATA_W-1:0] length_reg [MAX_PAIRS];
    logic [IDX_W-1:0]  perm_reg   [MAX_PAIRS];
    logic [IDX_W-1:0]  best_perm_reg [MAX_PAIRS];
    logic [COST_W-1:0] cost_stk_reg  [MAX_PAIRS];

    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     n_reg;
    logic [IDX_W-1:0]     lvl_reg;
    logic [CNT_W-1:0]     cand_reg;
    logic [MAX_PAIRS-1:0] used_reg;
    logic [COST_W-1:0]    best_cost_reg;
    logic [IDX_W-1:0]     out_idx_reg;

    logic              room;
    logic              cand_end;
    logic [IDX_W-1:0]  cand_idx;
    logic              cand_used;
    logic              at_leaf;
    logic [DATA_W-1:0] h_val;
    logic [DATA_W-1:0] l_val;
    logic [DATA_W-1:0] diff;
    logic [COST_W-1:0] step_cost;
    logic [IDX_W-1:0]  prev_idx;

    assign room      = count_reg < CNT_W'(MAX_PAIRS);
    assign cand_end  = cand_reg >= n_reg;
    assign cand_idx  = cand_reg[IDX_W-1:0];
    assign cand_used = used_reg[cand_idx];
    assign at_leaf   = (CNT_W'(lvl_reg) + CNT_W'(1)) == n_reg;
    assign h_val     = height_reg[lvl_reg];
    assign l_val     = length_reg[cand_idx];
    assign diff      = (h_val >= l_val) ? (h_val - l_val) : (l_val - h_val);
    assign step_cost = cost_stk_reg[lvl_reg] + COST_W'(diff);
    assign prev_idx  = perm_reg[lvl_reg - IDX_W'(1)];

    assign status.search_done = cand_end && (lvl_reg == '0);
    assign status.emit_last   = (CNT_W'(out_idx_reg) + CNT_W'(1)) == n_reg;

    assign out_person = PIDX_W'(out_idx_reg);
    assign out_item   = ITEM_W'(best_perm_reg[out_idx_reg]) + ITEM_W'(1);
    assign out_cost   = best_cost_reg[OUT_COST_W-1:0];

    // stores, stacks and best permutation: payload, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.load && room)
        begin
            height_reg[count_reg[IDX_W-1:0]] <= in_height;
            length_reg[count_reg[IDX_W-1:0]] <= in_length;
        end
        if (cmd.start)
        begin
            cost_stk_reg[0] <= '0;
        end
        if (cmd.step && !cand_end && !cand_used)
        begin
            if (at_leaf)
            begin
                if (step_cost < best_cost_reg)
                begin
                    for (int i = 0; i < MAX_PAIRS; i++)
                    begin
                        best_perm_reg[i] <= (IDX_W'(i) == lvl_reg) ? cand_idx : perm_reg[i];
                    end
                end
            end
            else
            begin
                perm_reg[lvl_reg]                  <= cand_idx;
                cost_stk_reg[lvl_reg + IDX_W'(1)] <= step_cost;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            n_reg         <= CNT_W'(1);
            lvl_reg       <= '0;
            cand_reg      <= '0;
            used_reg      <= '0;
            best_cost_reg <= COST_ALL_ONES;
            out_idx_reg   <= '0;
        end
        else
        begin
            if (cmd.start)
            begin
                n_reg         <= room ? (count_reg + CNT_W'(1)) : count_reg;
                count_reg     <= '0;
                lvl_reg       <= '0;
                cand_reg      <= '0;
                used_reg      <= '0;
                best_cost_reg <= COST_ALL_ONES;
                out_idx_reg   <= '0;
            end
            else if (cmd.load && room)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end

            if (cmd.step)
            begin
                if (cand_end)
                begin
                    // candidates exhausted: backtrack one level
                    if (lvl_reg != '0)
                    begin
                        used_reg[prev_idx] <= 1'b0;
                        lvl_reg            <= lvl_reg - IDX_W'(1);
                        cand_reg           <= CNT_W'(prev_idx) + CNT_W'(1);
                    end
                end
                else if (cand_used)
                begin
                    cand_reg <= cand_reg + CNT_W'(1);
                end
                else if (at_leaf)
                begin
                    if (step_cost < best_cost_reg)
                    begin
                        best_cost_reg <= step_cost;
                    end
                    cand_reg <= cand_reg + CNT_W'(1);
                end
                else
                begin
                    used_reg[cand_idx] <= 1'b1;
                    lvl_reg            <= lvl_reg + IDX_W'(1);
                    cand_reg           <= '0;
                end
            end

            if (cmd.emit_adv)
            begin
                out_idx_reg <= out_idx_reg + IDX_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

[rtl/min_abs_diff_assignment_search_core.sv]
`default_nettype none

// Load: one pair item per cycle while s_tready is high.
// Search: depth-first walk over all assignments, one candidate test or backtrack step per cycle.
// Emit: n result items, one per cycle while m_tready is high; then loading resumes.
// Reset: asynchronous, active low; returns to loading with an empty set.
module min_abs_diff_assignment_search_core
#(
    parameter int MAX_PAIRS = mads_pkg::MAX_PAIRS_DEF
)
(
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    // [9:0] person_height, [19:10] item_length, [23:20] zero
    input  wire  [mads_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  wire                                 s_tlast,   // final_pair
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    // [2:0] person_index, [6:3] assigned_item, [19:7] total_cost, [23:20] zero
    output logic [mads_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic                                m_tlast    // run_end
);
    import mads_pkg::*;

    cmd_t    cmd;
    status_t status;

    logic [PIDX_W-1:0]     out_person;
    logic [ITEM_W-1:0]     out_item;
    logic [OUT_COST_W-1:0] out_cost;

    mads_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_last   (s_tlast),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    mads_datapath #(
        .MAX_PAIRS (MAX_PAIRS)
    ) u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .in_height  (s_tdata[DATA_W-1:0]),
        .in_length  (s_tdata[2*DATA_W-1:DATA_W]),
        .status     (status),
        .out_person (out_person),
        .out_item   (out_item),
        .out_cost   (out_cost)
    );

    assign m_tdata = {(OUT_TDATA_W - OUT_COST_W - ITEM_W - PIDX_W)'(0),
                      out_cost, out_item, out_person};
    assign m_tlast = status.emit_last;

`ifndef NO_ASSERTIONS
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input and output open at once");

    a_search_after_final: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> (!s_tready && !m_tvalid))
        else $error("search skipped after final item");

    a_load_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
        else $error("loading not resumed after last result");
`endif

endmodule

`default_nettype wire

[bench/min_abs_diff_assignment_search_core_test.sv]
`timescale 1ns / 1ps

module min_abs_diff_assignment_search_core_test;
    import mads_pkg::*;

    localparam int PAIR_DEPTH  = MAX_PAIRS_DEF;
    localparam int IDLE_PCT    = 18;
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int TAIL_CYCLES = 50;
    localparam int HOLD_CYCLES = 400;
    localparam int RANDOM_ITEMS = 346;

    typedef struct packed {
        logic [DATA_W-1:0] height;
        logic [DATA_W-1:0] length;
        logic              final_pair;
        logic              drain_first;  // hold this item until all results are in
    } pair_item_t;

    typedef struct packed {
        logic [PIDX_W-1:0]     person;
        logic [ITEM_W-1:0]     item;
        logic [OUT_COST_W-1:0] cost;
        logic                  run_end;
    } assign_result_t;

    logic                   clk;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   s_tlast  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;

    pair_item_t     pair_q[$];
    assign_result_t result_q[$];

    // predictor copy of the set being loaded
    logic [DATA_W-1:0] held_height[PAIR_DEPTH];
    logic [DATA_W-1:0] held_length[PAIR_DEPTH];
    logic [ITEM_W-1:0] best_item[PAIR_DEPTH];
    int                held_count = 0;

    int fail_count = 0;
    int recv_count = 0;
    int sent_count = 0;

    min_abs_diff_assignment_search_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Walks all permutations in lexicographic order, keeps the first minimum.
    function automatic logic [COST_W-1:0] solve_assignment(int n);
        int               perm[PAIR_DEPTH];
        int               i;
        int               j;
        int               t;
        int               lo;
        int               hi;
        bit               more;
        logic [COST_W-1:0] sum;
        logic [COST_W-1:0] best;
        for (i = 0; i < n; i++)
            perm[i] = i;
        best = COST_ALL_ONES;
        more = 1'b1;
        while (more)
        begin
            sum = '0;
            for (i = 0; i < n; i++)
            begin
                if (held_height[i] > held_length[perm[i]])
                    sum += COST_W'(held_height[i] - held_length[perm[i]]);
                else
                    sum += COST_W'(held_length[perm[i]] - held_height[i]);
            end
            if (sum < best)
            begin
                best = sum;
                for (i = 0; i < n; i++)
                    best_item[i] = ITEM_W'(perm[i] + 1);
            end
            i = n - 1;
            while (i > 0 && perm[i-1] >= perm[i])
                i--;
            if (i <= 0)
                more = 1'b0;
            else
            begin
                j = n - 1;
                while (perm[j] <= perm[i-1])
                    j--;
                t = perm[i-1];
                perm[i-1] = perm[j];
                perm[j] = t;
                lo = i;
                hi = n - 1;
                while (lo < hi)
                begin
                    t = perm[lo];
                    perm[lo] = perm[hi];
                    perm[hi] = t;
                    lo++;
                    hi--;
                end
            end
        end
        return best;
    endfunction

    function automatic logic [DATA_W-1:0] pick_value(int mode, int base);
        int v;
        case (mode)
            0: v = $urandom_range(1023);
            1: v = $urandom_range(7);           // dense ties
            2:
            begin
                v = base + int'($urandom_range(30)) - 15;
                if (v < 0)
                    v = 0;
                if (v > 1023)
                    v = 1023;
            end
            default: v = $urandom_range(1) ? 1023 : $urandom_range(1) ? 0 : $urandom_range(1023);
        endcase
        return DATA_W'(v);
    endfunction

    task automatic add_pair(input int h, input int l, input bit fin, input bit drain);
        pair_item_t p;
        p.height      = DATA_W'(h);
        p.length      = DATA_W'(l);
        p.final_pair  = fin;
        p.drain_first = drain;
        pair_q.push_back(p);
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
        end
        else
        begin : drive_pairs
            pair_item_t nxt;
            bit         steady;
            bit         blocked;
            if (s_tvalid && s_tready)
                sent_count++;
            steady = sent_count >= 150 && sent_count < 230;
            if (!s_tvalid || s_tready)
            begin
                blocked = pair_q.size() != 0 && pair_q[0].drain_first &&
                          (result_q.size() != 0 || (s_tvalid && s_tready && s_tlast));
                if (pair_q.size() != 0 && !blocked &&
                    (steady || $urandom_range(99) >= IDLE_PCT))
                begin
                    nxt = pair_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {{(IN_TDATA_W - 2*DATA_W){1'b0}}, nxt.length, nxt.height};
                    s_tlast  <= nxt.final_pair;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random stalls, one long hold-off once results are flowing
    int  hold_left = 0;
    bit  hold_done = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && recv_count >= 40 && m_tvalid)
        begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
            m_tready <= (recv_count >= 120 && recv_count < 220) ||
                        ($urandom_range(99) >= IDLE_PCT);
    end

    // prediction on accepted pairs, checking on accepted results
    always @(posedge clk)
    begin : track
        int                i;
        logic [COST_W-1:0] cost;
        assign_result_t    want;
        assign_result_t    got;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                // a pair beyond capacity is dropped, but a final one still starts the search
                if (held_count < PAIR_DEPTH)
                begin
                    held_height[held_count] = s_tdata[DATA_W-1:0];
                    held_length[held_count] = s_tdata[2*DATA_W-1:DATA_W];
                    held_count++;
                end
                if (s_tlast)
                begin
                    cost = solve_assignment(held_count);
                    for (i = 0; i < held_count; i++)
                    begin
                        want.person  = PIDX_W'(i);
                        want.item    = best_item[i];
                        want.cost    = cost[OUT_COST_W-1:0];
                        want.run_end = (i == held_count - 1);
                        result_q.push_back(want);
                    end
                    held_count = 0;
                end
            end
            if (m_tvalid && m_tready)
            begin
                recv_count <= recv_count + 1;
                got.person  = m_tdata[PIDX_W-1:0];
                got.item    = m_tdata[PIDX_W+ITEM_W-1:PIDX_W];
                got.cost    = m_tdata[PIDX_W+ITEM_W+OUT_COST_W-1:PIDX_W+ITEM_W];
                got.run_end = m_tlast;
                if (result_q.size() == 0)
                begin
                    $display("%0t: unexpected result item, expected none, actual tdata %h tlast %b",
                             $time, m_tdata, m_tlast);
                    fail_count++;
                end
                else
                begin
                    want = result_q.pop_front();
                    if (got.person !== want.person)
                    begin
                        $display("%0t: person_index expected %0d actual %0d",
                                 $time, want.person, got.person);
                        fail_count++;
                    end
                    if (got.item !== want.item)
                    begin
                        $display("%0t: assigned_item expected %0d actual %0d",
                                 $time, want.item, got.item);
                        fail_count++;
                    end
                    if (got.cost !== want.cost)
                    begin
                        $display("%0t: total_cost expected %0d actual %0d",
                                 $time, want.cost, got.cost);
                        fail_count++;
                    end
                    if (got.run_end !== want.run_end)
                    begin
                        $display("%0t: run_end expected %0b actual %0b",
                                 $time, want.run_end, got.run_end);
                        fail_count++;
                    end
                end
            end
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("min_abs_diff_assignment_search_core verification failed");
        $finish;
    end

    initial
    begin : stimulus
        int i;
        int n;
        int r;
        int mode;
        int base;
        int total;
        bit drain;

        // single pairs at the extremes
        add_pair(0, 1023, 1, 0);
        add_pair(1023, 1023, 1, 0);
        // crossed pair: the swap wins with zero cost
        add_pair(0, 1023, 0, 0);
        add_pair(1023, 0, 1, 0);
        // all-equal set: every assignment ties, the first one is kept
        add_pair(5, 5, 0, 0);
        add_pair(5, 5, 0, 0);
        add_pair(5, 5, 1, 0);
        // seven random pairs, sent only once the block is drained
        for (i = 0; i < 7; i++)
            add_pair($urandom_range(1023), $urandom_range(1023), i == 6, i == 0);
        // full set at maximum cost, then an extra pair and a final pair that are dropped
        for (i = 0; i < PAIR_DEPTH; i++)
            add_pair(1023, 0, 0, i == 0);
        add_pair(0, 1023, 0, 0);
        add_pair(512, 512, 1, 0);

        total = 0;
        while (total < RANDOM_ITEMS)
        begin
            r = $urandom_range(99);
            n = r < 20 ? 1 : r < 45 ? 2 : r < 68 ? 3 : r < 86 ? 4 : r < 95 ? 5 : 6;
            mode  = $urandom_range(3);
            base  = $urandom_range(1023);
            drain = $urandom_range(24) == 0;
            for (i = 0; i < n; i++)
                add_pair(pick_value(mode, base), pick_value(mode, base),
                         i == n - 1, drain && i == 0);
            total += n;
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        wait (pair_q.size() == 0 && !s_tvalid);
        wait (result_q.size() == 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("min_abs_diff_assignment_search_core verification clean");
        else
            $display("min_abs_diff_assignment_search_core verification failed");
        $finish;
    end

endmodule

[files.f]
rtl/mads_pkg.sv
rtl/mads_ctrl.sv
rtl/mads_datapath.sv
rtl/min_abs_diff_assignment_search_core.sv
bench/min_abs_diff_assignment_search_core_test.sv
